### rtl/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// Depends on nothing; every other file in rtl uses it by scoped names.
package mexp_pkg;

  // Datapath width; only the low Width bits of each input field take part.
  localparam int unsigned Width  = 64;
  // Width of the fields as they travel on the ports.
  localparam int unsigned FieldW = 64;
  // Bit counter width of the serial multiplier (counts Width-1 down to 0).
  localparam int unsigned CntW   = $clog2(Width);

  typedef struct packed {
    logic [FieldW-1:0] base_value;
    logic [FieldW-1:0] exponent_value;
    logic [FieldW-1:0] modulus_value;
  } mexp_in_t;

  typedef struct packed {
    logic [FieldW-1:0] power_result;
    logic              modulus_error;
  } mexp_out_t;

  // Status of one serial modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mexp_mul_stat_t;

endpackage

### rtl/mexp_mulmod.sv
// Bit-serial modular multiplier: p = (a * b) mod m, one bit of b per cycle.
// Depends on mexp_pkg. Needs a < m; b may hold any value.
module mexp_mulmod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mexp_pkg::Width-1:0]  a_i,
  input  logic [mexp_pkg::Width-1:0]  b_i,
  input  logic [mexp_pkg::Width-1:0]  m_i,
  output mexp_pkg::mexp_mul_stat_t    stat_o,
  output logic [mexp_pkg::Width-1:0]  p_o
);

  logic [mexp_pkg::Width-1:0] acc_q, acc_d;
  logic [mexp_pkg::Width-1:0] b_q;
  logic [mexp_pkg::CntW-1:0]  cnt_q;
  logic                       busy_q;
  logic                       done_q;

  logic [mexp_pkg::Width:0]   dbl;
  logic [mexp_pkg::Width:0]   m_ext;
  logic [mexp_pkg::Width-1:0] dbl_red;
  logic [mexp_pkg::Width:0]   sum;
  logic [mexp_pkg::Width:0]   sum_red;

  // Doubling then conditional add, each followed by one compare and subtract.
  // The accumulator stays below m throughout, so one subtraction suffices.
  always_comb begin
    m_ext   = {1'b0, m_i};
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= m_ext) ? mexp_pkg::Width'(dbl - m_ext)
                             : dbl[mexp_pkg::Width-1:0];
    sum     = {1'b0, dbl_red} + {1'b0, a_i};
    sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    acc_d   = b_q[mexp_pkg::Width-1] ? sum_red[mexp_pkg::Width-1:0] : dbl_red;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= mexp_pkg::CntW'(mexp_pkg::Width - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      b_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[mexp_pkg::Width-2:0], 1'b0};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign p_o         = acc_q;

endmodule

### rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: sequencer and two serial
// multipliers. Depends on mexp_pkg and mexp_mulmod.
//
// A transaction is taken when start is high while busy is low; it carries a
// base, an exponent and a modulus, of which the low 64 bits are used. The
// block answers each transaction with exactly one result, held on result_o
// for the single cycle in which result_valid_o is high; the receiver cannot
// hold it off, so it must take the result in that cycle. A zero modulus
// gives power_result 0 with modulus_error set, and a zero exponent gives 1;
// both answer in the cycle after acceptance and leave busy low, so a new
// transaction may follow at once. Otherwise the base is first reduced modulo
// the modulus, then the exponent is scanned from its least significant bit
// upward: on each bit the running base is squared and, when the bit is set,
// the accumulator is multiplied by it, both multiplications running side by
// side. Each modular multiplication walks one bit of its multiplier per cycle.
// busy stays high from acceptance until the result is presented.
module modular_exponentiation (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mexp_pkg::mexp_in_t  data_i,
  output logic                result_valid_o,
  output mexp_pkg::mexp_out_t result_o
);

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StRedGo    = 3'd1;
  localparam logic [2:0] StRedWait  = 3'd2;
  localparam logic [2:0] StStepGo   = 3'd3;
  localparam logic [2:0] StStepWait = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [mexp_pkg::Width-1:0] base_q, base_d;
  logic [mexp_pkg::Width-1:0] exp_q, exp_d;
  logic [mexp_pkg::Width-1:0] mod_q, mod_d;
  logic [mexp_pkg::Width-1:0] acc_q, acc_d;
  mexp_pkg::mexp_out_t        result_q, result_d;
  logic                       result_valid_q, result_valid_d;

  logic                       reducing;
  logic [mexp_pkg::Width-1:0] one_red;
  logic                       mul_start, sq_start;
  logic [mexp_pkg::Width-1:0] mul_a, mul_b;
  logic [mexp_pkg::Width-1:0] mul_p, sq_p;
  mexp_pkg::mexp_mul_stat_t   mul_stat, sq_stat;

  // The first unit does double duty: it reduces the incoming base (as
  // (1 mod m) * base) and later forms accumulator times base. The second
  // unit only squares the base. Operands come straight from the registers,
  // which hold still while the units run.
  assign reducing = (state_q == StRedGo) || (state_q == StRedWait);
  assign one_red  = (mod_q == mexp_pkg::Width'(1)) ? '0 : mexp_pkg::Width'(1);
  assign mul_a    = reducing ? one_red : base_q;
  assign mul_b    = reducing ? base_q  : acc_q;

  mexp_mulmod u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (mod_q),
    .stat_o  (mul_stat),
    .p_o     (mul_p)
  );

  mexp_mulmod u_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .a_i     (base_q),
    .b_i     (base_q),
    .m_i     (mod_q),
    .stat_o  (sq_stat),
    .p_o     (sq_p)
  );

  always_comb begin
    state_d        = state_q;
    base_d         = base_q;
    exp_d          = exp_q;
    mod_d          = mod_q;
    acc_d          = acc_q;
    result_d       = result_q;
    result_valid_d = 1'b0;
    mul_start      = 1'b0;
    sq_start       = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          base_d = data_i.base_value[mexp_pkg::Width-1:0];
          exp_d  = data_i.exponent_value[mexp_pkg::Width-1:0];
          mod_d  = data_i.modulus_value[mexp_pkg::Width-1:0];
          acc_d  = mexp_pkg::Width'(1);
          if (data_i.modulus_value[mexp_pkg::Width-1:0] == '0) begin
            // Zero modulus: flagged, answer is zero whatever the exponent.
            result_d.power_result  = '0;
            result_d.modulus_error = 1'b1;
            result_valid_d         = 1'b1;
          end else if (data_i.exponent_value[mexp_pkg::Width-1:0] == '0) begin
            // Zero exponent gives one with no reduction, even for modulus one.
            result_d.power_result  = mexp_pkg::FieldW'(1);
            result_d.modulus_error = 1'b0;
            result_valid_d         = 1'b1;
          end else begin
            state_d = StRedGo;
          end
        end
      end
      StRedGo: begin
        mul_start = 1'b1;
        state_d   = StRedWait;
      end
      StRedWait: begin
        if (mul_stat.done) begin
          base_d  = mul_p;
          state_d = StStepGo;
        end
      end
      StStepGo: begin
        mul_start = exp_q[0];
        sq_start  = 1'b1;
        state_d   = StStepWait;
      end
      StStepWait: begin
        // The squaring unit always runs and any multiplication starts with it, so
        // the squaring unit's finish marks the end of the step.
        if (sq_stat.done) begin
          base_d = sq_p;
          exp_d  = exp_q >> 1;
          if (exp_q[0]) begin
            acc_d = mul_p;
          end
          if (exp_q[mexp_pkg::Width-1:1] == '0) begin
            result_d.power_result  = mexp_pkg::FieldW'(exp_q[0] ? mul_p : acc_q);
            result_d.modulus_error = 1'b0;
            result_valid_d         = 1'b1;
            state_d                = StIdle;
          end else begin
            state_d = StStepGo;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    exp_q    <= exp_d;
    mod_q    <= mod_d;
    acc_q    <= acc_d;
    result_q <= result_d;
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // The squaring unit only finishes while the sequencer is waiting on a step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_stat.done |-> (state_q == StStepWait))
    else $error("squaring unit finished outside a step");

  // The units never run while the block reports itself idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (!mul_stat.busy && !sq_stat.busy))
    else $error("multiplier running while idle");

  // An error result always carries a zero power.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.modulus_error) |-> (result_o.power_result == '0))
    else $error("error result with nonzero power");

  // A result follows either an immediate answer from idle or the last step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == StIdle || $past(state_q) == StStepWait))
    else $error("result strobe from an unexpected state");

endmodule

### tb/modular_exponentiation_test.sv
// Self-checking testbench for the modular exponentiation block.
// Needs mexp_pkg and the block's RTL. It predicts each power itself and
// checks every result strobe against the oldest outstanding prediction.
`timescale 1ns / 1ps

module modular_exponentiation_test;

  // Generous cycle limit. The slowest correct run is about 100 transactions,
  // each with a full-width exponent, plus idle gaps between transactions.
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned RandomCount = 80;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  // Largest prime below 2**64.
  localparam logic [63:0] BigPrime = 64'hFFFF_FFFF_FFFF_FFC5;

  // Scoreboard. It keeps the predicted results in order of acceptance. The
  // block answers strictly in order, one result per transaction.
  class power_checker;
    mexp_pkg::mexp_out_t pending_powers[$];
    int unsigned         fails;

    function new();
      fails = 0;
    endfunction

    // Works out (a * x) mod m with a double-width product, so nothing is lost.
    function logic [mexp_pkg::Width-1:0] mul_reduce(logic [mexp_pkg::Width-1:0] a,
                                                    logic [mexp_pkg::Width-1:0] x,
                                                    logic [mexp_pkg::Width-1:0] m);
      logic [2*mexp_pkg::Width-1:0] prod;
      prod = {{mexp_pkg::Width{1'b0}}, a} * {{mexp_pkg::Width{1'b0}}, x};
      return mexp_pkg::Width'(prod % {{mexp_pkg::Width{1'b0}}, m});
    endfunction

    // Right-to-left square-and-multiply over the low Width bits of each field.
    // With a zero exponent the accumulator is never touched, so the answer is
    // 1 even when the modulus is 1.
    function mexp_pkg::mexp_out_t expected_power(mexp_pkg::mexp_in_t ops);
      logic [mexp_pkg::Width-1:0] run_base;
      logic [mexp_pkg::Width-1:0] expo;
      logic [mexp_pkg::Width-1:0] modv;
      logic [mexp_pkg::Width-1:0] acc;
      mexp_pkg::mexp_out_t        res;
      run_base = ops.base_value[mexp_pkg::Width-1:0];
      expo     = ops.exponent_value[mexp_pkg::Width-1:0];
      modv     = ops.modulus_value[mexp_pkg::Width-1:0];
      res      = '0;
      if (modv == '0) begin
        res.modulus_error = 1'b1;
        return res;
      end
      acc = 1;
      for (int i = 0; i < mexp_pkg::Width; i++) begin
        if (expo[i]) acc = mul_reduce(acc, run_base, modv);
        run_base = mul_reduce(run_base, run_base, modv);
      end
      res.power_result = mexp_pkg::FieldW'(acc);
      return res;
    endfunction

    function void note_operands(mexp_pkg::mexp_in_t ops);
      pending_powers.push_back(expected_power(ops));
    endfunction

    function void check_power(mexp_pkg::mexp_out_t got);
      mexp_pkg::mexp_out_t want;
      if (pending_powers.size() == 0) begin
        $error("result with none outstanding: power_result %h, modulus_error %b",
               got.power_result, got.modulus_error);
        fails++;
        return;
      end
      want = pending_powers.pop_front();
      if (got.power_result !== want.power_result) begin
        $error("power_result: expected %h, got %h", want.power_result, got.power_result);
        fails++;
      end
      if (got.modulus_error !== want.modulus_error) begin
        $error("modulus_error: expected %b, got %b", want.modulus_error, got.modulus_error);
        fails++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_powers.size();
    endfunction
  endclass

  logic                clk    = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start  = 1'b0;
  mexp_pkg::mexp_in_t  data_i = '0;
  logic                busy;
  logic                result_valid_o;
  mexp_pkg::mexp_out_t result_o;

  power_checker ledger = new();
  int unsigned  cycles = 0;
  bit           idling_on = 1'b1;

  modular_exponentiation uut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .data_i        (data_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung block must not hang the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Monitor. It samples the values from before the edge, because the block
  // and the driver both update with nonblocking assignments. A transaction
  // is taken when start is high and busy is low. A result is valid for
  // exactly one cycle.
  always @(posedge clk) begin
    if (rst_ni) begin
      if (result_valid_o) ledger.check_power(result_o);
      if (start && !busy) ledger.note_operands(data_i);
    end
  end

  // Presents one transaction and holds it until the block takes it. The task
  // returns on the accepting edge with start still high. The next call can
  // then keep start high, so there are no back-to-back gaps.
  task automatic send_operands(input logic [63:0] b, input logic [63:0] e,
                               input logic [63:0] m);
    start  <= 1'b1;
    data_i <= '{base_value: b, exponent_value: e, modulus_value: m};
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // The sender sometimes goes quiet for a short burst. Because the sender waits
  // on busy, these gaps begin just after the block has taken a transaction.
  task automatic maybe_idle();
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Holds off until the block has answered everything taken so far.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (ledger.outstanding() != 0);
  endtask

  // Random value confined to its low 'bits' bits.
  function automatic logic [63:0] rand_span(int unsigned bits);
    logic [63:0] w;
    w = {$urandom, $urandom};
    if (bits < 64) w &= (64'd1 << bits) - 64'd1;
    return w;
  endfunction

  function automatic int unsigned pick_span();
    return $urandom_range(0, 1) ? 64 : $urandom_range(1, 64);
  endfunction

  task automatic run_directed();
    // Zero modulus: flagged whatever the exponent, including zero.
    send_operands(64'd0, 64'd0, 64'd0);                  maybe_idle();
    send_operands(64'd5, 64'd7, 64'd0);                  maybe_idle();
    send_operands(AllOnes, AllOnes, 64'd0);              maybe_idle();
    // Zero exponent gives 1 without reduction, even when the modulus is 1.
    send_operands(64'd123, 64'd0, 64'd1);                maybe_idle();
    send_operands(AllOnes, 64'd0, AllOnes);              maybe_idle();
    send_operands(64'd0, 64'd0, 64'd97);                 maybe_idle();
    // Zero base, exponent 1, and a base at or above the modulus.
    send_operands(64'd0, 64'd5, 64'd97);                 maybe_idle();
    send_operands(AllOnes, 64'd1, AllOnes);              maybe_idle();
    send_operands(AllOnes, 64'd1, AllOnes - 64'd1);      maybe_idle();
    send_operands(64'd1000, 64'd3, 64'd7);               maybe_idle();
    send_operands(64'd2, 64'd10, 64'd1000);              maybe_idle();
    // Modulus 1 with a full exponent collapses everything to 0.
    send_operands(64'd7, AllOnes, 64'd1);                maybe_idle();
    // Full-width operands near the top of the range.
    send_operands(AllOnes, AllOnes, BigPrime);           maybe_idle();
    send_operands(64'd3, BigPrime - 64'd1, BigPrime);    maybe_idle();
    send_operands(64'd2, 64'd64, AllOnes);               maybe_idle();
    send_operands(64'h8000_0000_0000_0000, 64'd2, 64'd3); maybe_idle();
    send_operands(AllOnes, 64'd2, 64'd2);                maybe_idle();
    send_operands(64'd12345, 64'd65537, 64'h8000_0000_0000_0000); maybe_idle();
    // Only the top exponent bit is set, so the accumulator is multiplied only in the last step.
    send_operands(64'hDEAD_BEEF_CAFE_F00D, 64'h8000_0000_0000_0000, AllOnes);
    maybe_idle();
    send_operands(AllOnes, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  task automatic run_random();
    int unsigned sel;
    logic [63:0] b;
    logic [63:0] e;
    logic [63:0] m;
    for (int k = 0; k < RandomCount; k++) begin
      // The last fifth of the run goes back to back. Halfway through, the
      // sender waits until every outstanding result has come back.
      idling_on = (k < (RandomCount * 4) / 5);
      if (k == RandomCount / 2) drain_results();
      sel = $urandom_range(0, 99);
      m = rand_span(pick_span());
      b = $urandom_range(0, 1) ? rand_span(64) : rand_span(pick_span());
      e = rand_span(pick_span());
      if (sel < 8)       m = 64'd0;
      else if (sel < 15) e = 64'd0;
      else if (sel < 18) m = 64'd1;
      else if (sel < 21) b = 64'd0;
      send_operands(b, e, m);
      maybe_idle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    run_directed();
    // Every directed answer is in before the random part starts.
    drain_results();
    run_random();
    drain_results();
    // Stay a while longer so that a stray late strobe would still be caught.
    repeat (200) @(posedge clk);

    if (ledger.outstanding() != 0) begin
      $error("%0d results never arrived", ledger.outstanding());
      ledger.fails++;
    end
    if (ledger.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/modular_exponentiation.sv
tb/modular_exponentiation_test.sv
